// ===== rtl/catmull_rom_cycle_resampler_core_macros.svh =====
// assertion macros for the catmull-rom cycle resampler
// used by catmull_rom_cycle_resampler_core, no other dependencies
`ifndef CATMULL_ROM_CYCLE_RESAMPLER_CORE_MACROS_SVH
`define CATMULL_ROM_CYCLE_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CRCR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CRCR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CRCR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define CRCR_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/crcr_pkg.sv =====
// shared types and constants of the catmull-rom cycle resampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crcr_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int FRACTION_BITS      = 16;
    localparam int DEF_MAX_SOURCE_LEN = 2048;

    localparam int LEN_W     = 12;
    localparam int DEST_W    = 16;
    localparam int POS_W     = 32;
    localparam int POS_INT_W = POS_W - FRACTION_BITS;
    localparam int IDX_W     = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = DEST_W + LEN_W;
    localparam int DIV_W     = PROD_W + FRACTION_BITS;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int ACC_W     = 30;
    localparam int MUL_W     = ACC_W + FRACTION_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_INTERP   = 2'd1;
    localparam logic [1:0] CMD_RESAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LENGTH   = 2'd2;

    localparam logic [LEN_W-1:0]  SOURCE_LENGTH_RESET = '0;
    localparam logic              EDGE_MODE_RESET     = 1'b1;
    localparam logic [DEST_W-1:0] DEST_LENGTH_RESET   = 16'd2048;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_INTERP   = 2'd1,
        OP_RESAMPLE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic [IDX_W-1:0]               wr_index;
        logic signed [SAMPLE_BITS-1:0]  wr_value;
        logic signed [POS_INT_W-1:0]    pos_int;
        logic [FRACTION_BITS-1:0]       pos_frac;
        logic [PROD_W-1:0]              prod;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } fifo_stat_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DEST_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DEST_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic busy;
        logic div_wait;
    } back_stat_t;

endpackage

`default_nettype wire

// ===== rtl/catmull_rom_cycle_resampler_core.sv =====
// channel     | handshake               | payload
// s_ (input)  | s_valid / s_ready       | command, sample_index, sample_value, position, out_index
// m_ (result) | m_valid / m_ready       | interpolated_value
// cfg_        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// the front takes an item every cycle while the 4-entry queue has room
// the back runs one item at a time: a write completes in the idle state, a clamped interpolate
// reads its neighbours and runs horner, a wrapped interpolate first divides by the length
// and a resample divides twice; the 4-bit-per-cycle divider and the single sample memory port
// set the pace; reset is synchronous and active low; no memory clearing pass, the queue lets the
// input side keep taking items while a result waits in the output register
//
// top level of the catmull-rom cycle resampler
// depends on crcr_pkg, crcr_front, crcr_fifo, crcr_div, crcr_back and the macros header
`timescale 1ns / 1ps
`default_nettype none

`include "catmull_rom_cycle_resampler_core_macros.svh"

module catmull_rom_cycle_resampler_core #(
    parameter int MAX_SOURCE_LEN = crcr_pkg::DEF_MAX_SOURCE_LEN
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [crcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [crcr_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [1:0]                              s_command,
    input  wire logic [crcr_pkg::IDX_W-1:0]              s_sample_index,
    input  wire logic signed [crcr_pkg::SAMPLE_BITS-1:0] s_sample_value,
    input  wire logic signed [crcr_pkg::POS_W-1:0]       s_position,
    input  wire logic [crcr_pkg::DEST_W-1:0]             s_out_index,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [crcr_pkg::SAMPLE_BITS-1:0]      m_interpolated_value
);
    import crcr_pkg::*;

    logic [LEN_W-1:0]  src_len_reg;
    logic              edge_mode_reg;
    logic [DEST_W-1:0] dst_len_reg;
    logic [LEN_W-1:0]  n_len;

    logic       q_push;
    logic       q_pop;
    item_t      push_item;
    item_t      pop_item;
    fifo_stat_t fifo_stat;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    back_stat_t bk_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_len_reg   <= SOURCE_LENGTH_RESET;
            edge_mode_reg <= EDGE_MODE_RESET;
            dst_len_reg   <= DEST_LENGTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SOURCE_LENGTH: src_len_reg   <= cfg_data[LEN_W-1:0];
                REG_EDGE_MODE:     edge_mode_reg <= cfg_data[0];
                REG_DEST_LENGTH:   dst_len_reg   <= cfg_data[DEST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign n_len = (32'(src_len_reg) > 32'(MAX_SOURCE_LEN)) ? LEN_W'(MAX_SOURCE_LEN)
                                                            : src_len_reg;

    crcr_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_sample_index (s_sample_index),
        .s_sample_value (s_sample_value),
        .s_position     (s_position),
        .s_out_index    (s_out_index),
        .src_len        (n_len),
        .dst_len        (dst_len_reg),
        .q_stat         (fifo_stat),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    crcr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    crcr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    crcr_back #(
        .MAX_SOURCE_LEN (MAX_SOURCE_LEN)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .n_len                (n_len),
        .dst_len              (dst_len_reg),
        .edge_mode            (edge_mode_reg),
        .q_item               (pop_item),
        .q_stat               (fifo_stat),
        .q_pop                (q_pop),
        .div_req              (div_req),
        .div_rsp              (div_rsp),
        .stat                 (bk_stat),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_interpolated_value (m_interpolated_value)
    );

    `CRCR_ASSERT_IMP(a_queue_bound, aclk, aresetn, 1'b1, fifo_stat.count <= QUEUE_DEPTH)
    `CRCR_ASSERT_IMP(a_div_owner, aclk, aresetn, div_rsp.done, bk_stat.div_wait)
    `CRCR_ASSERT_IMP(a_result_source, aclk, aresetn, $rose(m_valid), $past(bk_stat.busy))
    `CRCR_ASSERT_NXT(a_queue_fill, aclk, aresetn, q_push && !q_pop && fifo_stat.count == 0, fifo_stat.valid)

endmodule

`default_nettype wire

// ===== rtl/crcr_front.sv =====
// front end: accepts items, classifies commands, forms the resample product
// depends on crcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcr_front (
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_command,
    input  wire logic [crcr_pkg::IDX_W-1:0]         s_sample_index,
    input  wire logic signed [crcr_pkg::SAMPLE_BITS-1:0] s_sample_value,
    input  wire logic signed [crcr_pkg::POS_W-1:0]  s_position,
    input  wire logic [crcr_pkg::DEST_W-1:0]        s_out_index,
    input  wire logic [crcr_pkg::LEN_W-1:0]         src_len,
    input  wire logic [crcr_pkg::DEST_W-1:0]        dst_len,
    input  wire crcr_pkg::fifo_stat_t               q_stat,
    output logic                                    q_push,
    output crcr_pkg::item_t                         q_item
);
    import crcr_pkg::*;

    logic keep;

    assign s_ready = !q_stat.full;

    always_comb begin
        keep            = 1'b0;
        q_item.op       = OP_WRITE;
        q_item.wr_index = s_sample_index;
        q_item.wr_value = s_sample_value;
        q_item.pos_int  = s_position[POS_W-1 -: POS_INT_W];
        q_item.pos_frac = s_position[FRACTION_BITS-1:0];
        q_item.prod     = PROD_W'(s_out_index) * PROD_W'(src_len);
        unique case (s_command)
            CMD_WRITE: begin
                keep      = 1'b1;
                q_item.op = OP_WRITE;
            end
            CMD_INTERP: begin
                keep      = 1'b1;
                q_item.op = OP_INTERP;
            end
            CMD_RESAMPLE: begin
                keep      = (dst_len != '0);
                q_item.op = OP_RESAMPLE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = s_valid && s_ready && keep;

endmodule

`default_nettype wire

// ===== rtl/crcr_fifo.sv =====
// short item queue between front and back
// depends on crcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcr_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire crcr_pkg::item_t push_item,
    input  wire logic            pop,
    output crcr_pkg::item_t      pop_item,
    output crcr_pkg::fifo_stat_t stat
);
    import crcr_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = slot_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/crcr_div.sv =====
// iterative restoring divider, DIV_STEP quotient bits per cycle
// depends on crcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module crcr_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire crcr_pkg::div_req_t req,
    output crcr_pkg::div_rsp_t      rsp
);
    import crcr_pkg::*;

    localparam int CNT_W = $clog2(DIV_ITER + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DEST_W-1:0] rem_reg;
    logic [DEST_W-1:0] dvs_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [DEST_W-1:0] rem_next;
    logic [DEST_W:0]   part;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        part     = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            part     = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (part >= {1'b0, dvs_reg}) begin
                part        = part - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = part[DEST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_ITER);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/crcr_back.sv =====
// back end: sample memory, neighbour fetch, horner evaluation, result register
// depends on crcr_pkg; drives the crcr_div divider through its div_req and div_rsp ports
`timescale 1ns / 1ps
`default_nettype none

module crcr_back #(
    parameter int MAX_SOURCE_LEN = crcr_pkg::DEF_MAX_SOURCE_LEN
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [crcr_pkg::LEN_W-1:0]         n_len,
    input  wire logic [crcr_pkg::DEST_W-1:0]        dst_len,
    input  wire logic                               edge_mode,
    input  wire crcr_pkg::item_t                    q_item,
    input  wire crcr_pkg::fifo_stat_t               q_stat,
    output logic                                    q_pop,
    output crcr_pkg::div_req_t                      div_req,
    input  wire crcr_pkg::div_rsp_t                 div_rsp,
    output crcr_pkg::back_stat_t                    stat,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [crcr_pkg::SAMPLE_BITS-1:0] m_interpolated_value
);
    import crcr_pkg::*;

    localparam int AW = $clog2(MAX_SOURCE_LEN);
    localparam logic signed [ACC_W:0] RND_ONE = 1;
    localparam logic signed [ACC_W:0] SAT_HI  = (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO  = (ACC_W+1)'(-(64'sd1 <<< (SAMPLE_BITS-1)));

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIVQ  = 9'b000000010,
        ST_DIVM  = 9'b000000100,
        ST_INDEX = 9'b000001000,
        ST_READ  = 9'b000010000,
        ST_COEF  = 9'b000100000,
        ST_HMUL  = 9'b001000000,
        ST_HADD  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_SOURCE_LEN];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          mem_we;
    logic [AW-1:0]                 mem_wa;
    logic [AW-1:0]                 mem_ra;

    logic                          neg_reg;
    logic [FRACTION_BITS-1:0]      frac_reg;
    logic [LEN_W-1:0]              r0_reg;
    logic [LEN_W-1:0]              idx_reg [4];
    logic signed [SAMPLE_BITS-1:0] x_reg [4];
    logic [2:0]                    cnt_reg;
    logic [1:0]                    step_reg;
    logic signed [ACC_W-1:0]       ca_reg;
    logic signed [ACC_W-1:0]       cb_reg;
    logic signed [ACC_W-1:0]       cc_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [MUL_W-1:0]       mul_reg;
    logic                          div_start_reg;
    logic [DIV_W-1:0]              div_dvd_reg;
    logic [DEST_W-1:0]             div_dvs_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_data_reg;

    logic [LEN_W-1:0]              n_m1;
    logic signed [POS_INT_W+1:0]   cl_v [4];
    logic [LEN_W-1:0]              cl_idx [4];
    logic [LEN_W-1:0]              wr_idx [4];
    logic signed [POS_INT_W:0]     pint_x;
    logic [POS_INT_W:0]            pmag;
    logic [LEN_W-1:0]              rem_n;
    logic [LEN_W-1:0]              r0_calc;
    logic signed [ACC_W-1:0]       xe [4];
    logic signed [ACC_W-1:0]       coef_a;
    logic signed [ACC_W-1:0]       coef_b;
    logic signed [ACC_W-1:0]       coef_c;
    logic signed [ACC_W-1:0]       coef_d;
    logic signed [ACC_W-1:0]       hsel;
    logic signed [ACC_W:0]         rnd_sum;
    logic signed [ACC_W:0]         rnd;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          out_free;
    logic                          is_zero;

    assign n_m1     = n_len - 1'b1;
    assign is_zero  = (n_len == '0);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_stat.valid;

    // clamp indices straight from the integer position
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cl_v[k] = (POS_INT_W+2)'(q_item.pos_int) + (POS_INT_W+2)'(k - 1);
            if (cl_v[k] < 0) begin
                cl_idx[k] = '0;
            end else if (cl_v[k] > $signed({6'b0, n_m1})) begin
                cl_idx[k] = n_m1;
            end else begin
                cl_idx[k] = cl_v[k][LEN_W-1:0];
            end
        end
    end

    always_comb begin
        pint_x  = (POS_INT_W+1)'(q_item.pos_int);
        pmag    = pint_x[POS_INT_W] ? (POS_INT_W+1)'(-pint_x) : (POS_INT_W+1)'(pint_x);
        rem_n   = div_rsp.remainder[LEN_W-1:0];
        r0_calc = (neg_reg && rem_n != '0) ? n_len - rem_n : rem_n;
    end

    // circular neighbours around r0
    always_comb begin
        wr_idx[1] = r0_reg;
        wr_idx[0] = (r0_reg == '0) ? n_m1 : r0_reg - 1'b1;
        wr_idx[2] = (r0_reg == n_m1) ? '0 : r0_reg + 1'b1;
        wr_idx[3] = (wr_idx[2] == n_m1) ? '0 : wr_idx[2] + 1'b1;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            xe[k] = ACC_W'(x_reg[k]);
        end
        coef_a = xe[1] + xe[1];
        coef_b = xe[2] - xe[0];
        coef_c = (xe[0] + xe[0]) - ((xe[1] <<< 2) + xe[1]) + (xe[2] <<< 2) - xe[3];
        coef_d = ((xe[1] <<< 1) + xe[1]) - xe[0] - ((xe[2] <<< 1) + xe[2]) + xe[3];
        unique case (step_reg)
            2'd0:    hsel = cc_reg;
            2'd1:    hsel = cb_reg;
            default: hsel = ca_reg;
        endcase
        rnd_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + RND_ONE;
        rnd     = rnd_sum >>> 1;
        if (rnd > SAT_HI) begin
            sat_val = SAMPLE_BITS'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            sat_val = SAMPLE_BITS'(SAT_LO);
        end else begin
            sat_val = SAMPLE_BITS'(rnd);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_stat.valid) begin
                    priority if (q_item.op == OP_WRITE) begin
                        state_next = ST_IDLE;
                    end else if (is_zero) begin
                        state_next = ST_OUT;
                    end else if (q_item.op == OP_RESAMPLE) begin
                        state_next = ST_DIVQ;
                    end else if (edge_mode) begin
                        state_next = ST_DIVM;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIVQ:  if (div_rsp.done) state_next = ST_DIVM;
            ST_DIVM:  if (div_rsp.done) state_next = ST_INDEX;
            ST_INDEX: state_next = ST_READ;
            ST_READ:  if (cnt_reg == 3'd4) state_next = ST_COEF;
            ST_COEF:  state_next = ST_HMUL;
            ST_HMUL:  state_next = ST_HADD;
            ST_HADD:  state_next = (step_reg == 2'd2) ? ST_OUT : ST_HMUL;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= 1'b0;
            if (q_pop && q_item.op != OP_WRITE && !is_zero
                    && (q_item.op == OP_RESAMPLE || edge_mode)) begin
                div_start_reg <= 1'b1;
            end
            if (state_reg == ST_DIVQ && div_rsp.done) begin
                div_start_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                frac_reg <= q_item.pos_frac;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                if (q_item.op == OP_RESAMPLE) begin
                    neg_reg     <= 1'b0;
                    div_dvd_reg <= {q_item.prod, FRACTION_BITS'(0)};
                    div_dvs_reg <= dst_len;
                end else begin
                    neg_reg     <= q_item.pos_int[POS_INT_W-1];
                    div_dvd_reg <= DIV_W'(pmag);
                    div_dvs_reg <= DEST_W'(n_len);
                end
                for (int k = 0; k < 4; k++) begin
                    idx_reg[k] <= cl_idx[k];
                end
            end
            ST_DIVQ: begin
                if (div_rsp.done) begin
                    frac_reg    <= div_rsp.quotient[FRACTION_BITS-1:0];
                    div_dvd_reg <= DIV_W'(div_rsp.quotient[DIV_W-1:FRACTION_BITS]);
                    div_dvs_reg <= DEST_W'(n_len);
                end
            end
            ST_DIVM: begin
                if (div_rsp.done) begin
                    r0_reg <= r0_calc;
                end
            end
            ST_INDEX: begin
                cnt_reg <= '0;
                for (int k = 0; k < 4; k++) begin
                    idx_reg[k] <= wr_idx[k];
                end
            end
            ST_READ: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    x_reg[cnt_reg[1:0] - 2'd1] <= rd_data_reg;
                end
            end
            ST_COEF: begin
                ca_reg   <= coef_a;
                cb_reg   <= coef_b;
                cc_reg   <= coef_c;
                acc_reg  <= coef_d;
                step_reg <= '0;
            end
            ST_HMUL: begin
                mul_reg <= acc_reg * $signed({1'b0, frac_reg});
            end
            ST_HADD: begin
                acc_reg  <= hsel + ACC_W'(mul_reg >>> FRACTION_BITS);
                step_reg <= step_reg + 1'b1;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg <= sat_val;
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign mem_we = q_pop && (q_item.op == OP_WRITE)
                    && (32'(q_item.wr_index) < 32'(MAX_SOURCE_LEN));
    assign mem_wa = AW'(q_item.wr_index);
    assign mem_ra = AW'(idx_reg[cnt_reg[1:0]]);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= q_item.wr_value;
        end else begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dvd_reg;
    assign div_req.divisor  = div_dvs_reg;

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.div_wait = (state_reg == ST_DIVQ) || (state_reg == ST_DIVM);

    assign m_valid              = m_valid_reg;
    assign m_interpolated_value = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for catmull_rom_cycle_resampler_core
// predicts every result in a small scoreboard class, drives random and directed items
// depends on crcr_pkg and the catmull_rom_cycle_resampler_core rtl
`timescale 1ns / 1ps

module testbench;
    import crcr_pkg::*;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int MEM_DEPTH = DEF_MAX_SOURCE_LEN;
    localparam int SETTLE_CYCLES = 100;

    class resample_scoreboard;
        int          samples [MEM_DEPTH];
        logic [11:0] src_len;
        bit          wrap_edges;
        logic [15:0] dest_len;
        logic [23:0] expected_q [$];
        int          errors;

        function new();
            src_len = SOURCE_LENGTH_RESET;
            wrap_edges = EDGE_MODE_RESET;
            dest_len = DEST_LENGTH_RESET;
            errors = 0;
            foreach (samples[k]) samples[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_SOURCE_LENGTH: src_len = data[11:0];
                REG_EDGE_MODE: wrap_edges = data[0];
                REG_DEST_LENGTH: dest_len = data;
                default: ;
            endcase
        endfunction

        function longint neighbor(longint idx, longint n, bit wrap);
            longint r;
            if (wrap) begin
                r = idx % n;
                if (r < 0) r += n;
            end else begin
                r = (idx < 0) ? 0 : ((idx > n - 1) ? n - 1 : idx);
            end
            return longint'(samples[r]);
        endfunction

        function logic [23:0] cubic(longint i, longint t, longint n, bit wrap);
            longint xm1, x0, x1, x2, a, b, c, d, acc, res;
            if (n == 0) return '0;
            if (n == 1) return samples[0][23:0];
            xm1 = neighbor(i - 1, n, wrap);
            x0 = neighbor(i, n, wrap);
            x1 = neighbor(i + 1, n, wrap);
            x2 = neighbor(i + 2, n, wrap);
            a = 2 * x0;
            b = x1 - xm1;
            c = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
            d = -xm1 + 3 * x0 - 3 * x1 + x2;
            acc = d;
            acc = c + ((acc * t) >>> FRACTION_BITS);
            acc = b + ((acc * t) >>> FRACTION_BITS);
            acc = a + ((acc * t) >>> FRACTION_BITS);
            res = (acc + 1) >>> 1;
            if (res > 64'sd8388607) res = 64'sd8388607;
            if (res < -64'sd8388608) res = -64'sd8388608;
            return res[23:0];
        endfunction

        function void note_input(logic [1:0] cmd, logic [10:0] idx, logic [23:0] val,
                                 logic [31:0] pos, logic [15:0] j);
            longint n, p, i, t, prod, ip, fr;
            n = (src_len > MEM_DEPTH) ? MEM_DEPTH : src_len;
            case (cmd)
                CMD_WRITE: samples[idx] = int'($signed(val));
                CMD_INTERP: begin
                    p = longint'($signed(pos));
                    i = p >>> FRACTION_BITS;
                    t = p - (i <<< FRACTION_BITS);
                    expected_q.insert(expected_q.size(), cubic(i, t, n, wrap_edges));
                end
                CMD_RESAMPLE: begin
                    if (dest_len != 0) begin
                        prod = longint'(j) * n;
                        ip = prod / dest_len;
                        fr = ((prod % dest_len) <<< FRACTION_BITS) / dest_len;
                        expected_q.insert(expected_q.size(), cubic(ip, fr, n, 1'b1));
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("error: %s", msg);
            errors++;
        endtask

        task check_result(logic [23:0] got);
            logic [23:0] want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    report($sformatf("interpolated_value %h, expected %h", got, want));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic [IDX_W-1:0] s_sample_index = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_value = '0;
    logic signed [POS_W-1:0] s_position = '0;
    logic [DEST_W-1:0] s_out_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_interpolated_value;

    resample_scoreboard sb = new();
    bit written [MEM_DEPTH];
    int burst_left = 0;
    bit gapless = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    catmull_rom_cycle_resampler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_sample_index(s_sample_index),
        .s_sample_value(s_sample_value), .s_position(s_position),
        .s_out_index(s_out_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_interpolated_value(m_interpolated_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stall pattern plus requested long hold-off
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 299) rx_mode <= $urandom_range(0, 3);
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= (rx_cycle % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_interpolated_value);
    end

    task automatic send_item(logic [1:0] cmd, logic [10:0] idx, logic [23:0] val,
                             logic [31:0] pos, logic [15:0] j);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_sample_index <= idx;
        s_sample_value <= val;
        s_position <= pos;
        s_out_index <= j;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, idx, val, pos, j);
        if (cmd == CMD_WRITE) written[idx] = 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 9) == 0) gapless = !gapless;
            if (!gapless) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic fill_source(int n);
        int lim;
        lim = (n > MEM_DEPTH) ? MEM_DEPTH : n;
        for (int k = 0; k < lim; k++)
            if (!written[k]) send_item(CMD_WRITE, 11'(k), 24'($urandom), $urandom,
                                       16'($urandom));
    endtask

    task automatic random_item();
        int pick, nn, ip, jmax;
        logic [23:0] val;
        logic [31:0] pos;
        logic [15:0] j;
        pick = $urandom_range(0, 99);
        nn = (sb.src_len > MEM_DEPTH) ? MEM_DEPTH : sb.src_len;
        val = 24'($urandom);
        if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        ip = $urandom_range(0, 4 * nn + 8) - (2 * nn + 4);
        pos = {ip[15:0], 16'($urandom)};
        if ($urandom_range(0, 7) == 0) pos = $urandom;
        jmax = 2 * sb.dest_len + 2;
        if (jmax > 65535) jmax = 65535;
        j = 16'($urandom_range(0, jmax));
        if ($urandom_range(0, 7) == 0) j = 16'($urandom);
        if (pick < 25) send_item(CMD_WRITE, 11'($urandom), val, pos, j);
        else if (pick < 60) send_item(CMD_INTERP, 11'($urandom), val, pos, j);
        else if (pick < 95) send_item(CMD_RESAMPLE, 11'($urandom), val, pos, j);
        else send_item(CMD_IGNORED, 11'($urandom), val, pos, j);
    endtask

    int phase_len [11] = '{16, 16, 2, 3, 64, 200, 150, 5, 37, 1, 0};
    bit phase_wrap [11] = '{0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 0};
    int phase_dest [11] = '{40, 16, 7, 1, 65535, 2048, 3000, 0, 100, 9, 5};
    logic [23:0] edge_vals [8] = '{24'h7fffff, 24'h800000, 24'h000000, 24'hffffff,
                                   24'h000001, 24'h7fffff, 24'h800000, 24'h003039};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty source and ignored command
        send_item(CMD_INTERP, 0, 0, 32'h0001_8000, 0);
        send_item(CMD_RESAMPLE, 0, 0, 0, 16'd5);
        send_item(CMD_IGNORED, 11'h7ff, 24'h7fffff, 32'hffffffff, 16'hffff);
        for (int k = 0; k < 8; k++) send_item(CMD_WRITE, 11'(k), edge_vals[k], 0, 0);
        drain();
        // single sample
        write_reg(REG_SOURCE_LENGTH, 16'd1);
        send_item(CMD_INTERP, 0, 0, 32'h7fffffff, 0);
        send_item(CMD_INTERP, 0, 0, 32'h80000000, 0);
        send_item(CMD_RESAMPLE, 0, 0, 0, 16'hffff);
        drain();
        // clamped and wrapped edges with overshoot
        write_reg(REG_SOURCE_LENGTH, 16'd8);
        for (int e = 0; e < 2; e++) begin
            write_reg(REG_EDGE_MODE, 16'(e));
            send_item(CMD_INTERP, 0, 0, 32'h7fffffff, 0);
            send_item(CMD_INTERP, 0, 0, 32'h80000000, 0);
            send_item(CMD_INTERP, 0, 0, 32'h0000ffff, 0);
            send_item(CMD_INTERP, 0, 0, 32'h0007ffff, 0);
            send_item(CMD_INTERP, 0, 0, 32'hffff8000, 0);
            send_item(CMD_RESAMPLE, 0, 0, 0, 16'hffff);
            drain();
        end
        // oversized source length, clamped reads at the top of memory
        write_reg(REG_SOURCE_LENGTH, 16'h0fff);
        write_reg(REG_EDGE_MODE, 16'd0);
        for (int k = 2044; k < 2048; k++) send_item(CMD_WRITE, 11'(k), 24'($urandom), 0, 0);
        send_item(CMD_INTERP, 0, 0, 32'h7fffffff, 0);
        send_item(CMD_INTERP, 0, 0, 32'h07fe8000, 0);
        send_item(CMD_INTERP, 0, 0, 32'h07fd4000, 0);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            fill_source(phase_len[ph]);
            drain();
            write_reg(REG_SOURCE_LENGTH, {4'($urandom), 12'(phase_len[ph])});
            write_reg(REG_EDGE_MODE, {15'($urandom), phase_wrap[ph]});
            write_reg(REG_DEST_LENGTH, 16'(phase_dest[ph]));
            for (int k = 0; k < 60; k++) begin
                if (ph == 3 && k == 20) hold_req++;
                if (ph == 5 && k == 45) drain();
                random_item();
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("catmull_rom_cycle_resampler_core: match");
        end else begin
            if (sb.expected_q.size() != 0)
                sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
            $display("catmull_rom_cycle_resampler_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("catmull_rom_cycle_resampler_core: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/crcr_pkg.sv
rtl/crcr_front.sv
rtl/crcr_fifo.sv
rtl/crcr_div.sv
rtl/crcr_back.sv
rtl/catmull_rom_cycle_resampler_core.sv
tb/sv/testbench.sv
